FILE: rtl/core/swis_pkg.sv
// ----------------------------------------------------------------------------
// swis_pkg
// Shared widths, defaults and types for the sliding-window inverse spread block.
// ----------------------------------------------------------------------------
package swis_pkg;

   localparam int IDX_W  = 13;
   localparam int SAMP_W = 16;
   localparam int SUM_W  = 24;
   localparam int SQ_W   = 40;
   localparam int INV_W  = 32;
   localparam int WIN_W  = 9;

   localparam int MAX_SERIES_DEF = 8192;

   localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(2);

   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic signed [SAMP_W-1:0] samp_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic signed [SQ_W-1:0]   sq_type;
   typedef logic [INV_W-1:0]         inv_type;

endpackage

FILE: rtl/core/swis_if.sv
// ----------------------------------------------------------------------------
// swis_req_if / swis_rsp_if
// Valid/ready channels carrying sample transactions in and results out.
// ----------------------------------------------------------------------------
interface swis_req_if;
   import swis_pkg::*;

   logic     valid;
   logic     ready;
   idx_type  series_index;
   samp_type new_sample;
   samp_type old_sample;
   logic     restart;

   modport source (output valid, output series_index, output new_sample,
                   output old_sample, output restart, input ready);
   modport sink   (input valid, input series_index, input new_sample,
                   input old_sample, input restart, output ready);
endinterface

interface swis_rsp_if;
   import swis_pkg::*;

   logic    valid;
   logic    ready;
   idx_type series_out;
   sum_type window_sum;
   inv_type inverse_spread;
   logic    zero_spread;

   modport source (output valid, output series_out, output window_sum,
                   output inverse_spread, output zero_spread, input ready);
   modport sink   (input valid, input series_out, input window_sum,
                   input inverse_spread, input zero_spread, output ready);
endinterface

FILE: rtl/core/sliding_window_inverse_spread.sv
// ----------------------------------------------------------------------------
// sliding_window_inverse_spread
// Per-series running sum and sum of squares with inverse spread output.
// ----------------------------------------------------------------------------
// The block handles one transaction at a time: it takes a transaction in
// the idle state, reduces the series index modulo MAX_SERIES by reciprocal
// multiplication (a quotient estimate, then a compare and subtract), reads
// the state memory, updates and writes back the series sums, forms the
// spread, runs the bit-serial divider for 2^62/spread and the bit-serial
// square root, and presents the result, which is held until rsp ready. When
// the spread is zero or negative the divider and square root are skipped.
// The divider and the square root take most of the time. After reset a
// clearing pass writes zero to every entry of the state memory, during
// which no transaction is taken; window size writes are taken at any time.
module sliding_window_inverse_spread #(
   parameter int MAX_SERIES = swis_pkg::MAX_SERIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   swis_req_if.sink                   req_ch,
   swis_rsp_if.source                 rsp_ch,
   input  logic                       csr_we,
   input  logic [swis_pkg::WIN_W-1:0] csr_wdata
);
   import swis_pkg::*;

   localparam int AW  = $clog2(MAX_SERIES);
   localparam int MW  = AW + 1;
   localparam int CW  = (IDX_W + 1 > MW) ? IDX_W + 1 : MW;
   localparam int DW  = 48;
   localparam int QW  = 63;
   localparam int EW  = SUM_W + SQ_W;
   localparam int RK  = 26;
   localparam int PW  = IDX_W + MW;
   localparam logic [AW-1:0] LAST_ENTRY = AW'(MAX_SERIES - 1);
   localparam logic [RK-1:0] RECIP = RK'((64'd1 << RK) / 64'(MAX_SERIES));

   typedef enum logic [9:0] {
      ST_CLEAR  = 10'b0000000001,
      ST_IDLE   = 10'b0000000010,
      ST_MOD    = 10'b0000000100,
      ST_READ   = 10'b0000001000,
      ST_UPDATE = 10'b0000010000,
      ST_MULT   = 10'b0000100000,
      ST_DIFF   = 10'b0001000000,
      ST_DIV    = 10'b0010000000,
      ST_SQRT   = 10'b0100000000,
      ST_DONE   = 10'b1000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [5:0]       step_ff, step_in;
   logic [WIN_W-1:0] win_ff, win_in;

   // Payload registers.
   idx_type            idx_ff;
   samp_type           nw_ff, od_ff;
   logic               rst_ff;
   logic [IDX_W-1:0]   qest_ff;
   logic [IDX_W-1:0]   mod_ff;
   logic signed [31:0] nsq_ff, osq_ff;
   logic [EW-1:0]      rdata_ff;
   sum_type            s_ff;
   sq_type             q_ff;
   logic signed [49:0] nq_ff;
   logic signed [47:0] ss_ff;
   logic [DW-1:0]      dvs_ff, rem_ff;
   logic [QW-1:0]      quo_ff, x_ff, r_ff, b_ff;
   inv_type            inv_ff;
   logic               zero_ff;

   logic [EW-1:0] mem [MAX_SERIES];

   // Index reduction by reciprocal multiplication. The quotient estimate is
   // the true quotient or one below it, so one compare and subtract finishes.
   logic [IDX_W+RK-1:0] quo_prod;
   logic [IDX_W-1:0]    quo_est;
   logic [PW-1:0]       quo_mul;
   logic [PW-1:0]       mod_diff;
   logic [CW-1:0]       mod_ext, slot_ext;
   logic [IDX_W-1:0]    mod_in;
   logic [AW-1:0]       addr;

   assign quo_prod = (IDX_W+RK)'(idx_ff) * (IDX_W+RK)'(RECIP);
   assign quo_est  = quo_prod[IDX_W+RK-1:RK];
   assign quo_mul  = PW'(qest_ff) * PW'(MAX_SERIES);
   assign mod_diff = PW'(idx_ff) - quo_mul;
   assign mod_ext  = mod_diff[CW-1:0];
   assign mod_in   = (mod_ext >= CW'(MAX_SERIES)) ?
                     IDX_W'(mod_ext - CW'(MAX_SERIES)) : IDX_W'(mod_ext);
   assign slot_ext = CW'(mod_ff);
   assign addr     = slot_ext[AW-1:0];

   // Sum update with saturation.
   sum_type            old_s;
   sq_type             old_q;
   logic signed [25:0] s_ext;
   logic signed [41:0] q_ext;
   sum_type            s_sat;
   sq_type             q_sat;

   assign old_s = rdata_ff[SUM_W-1:0];
   assign old_q = rdata_ff[EW-1:SUM_W];

   always_comb begin
      if (rst_ff) begin
         s_ext = 26'(nw_ff);
         q_ext = 42'(nsq_ff);
      end else begin
         s_ext = 26'(old_s) + 26'(nw_ff) - 26'(od_ff);
         q_ext = 42'(old_q) + 42'(nsq_ff) - 42'(osq_ff);
      end
      if (s_ext[25:SUM_W-1] != {3{s_ext[25]}}) begin
         s_sat = s_ext[25] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         s_sat = s_ext[SUM_W-1:0];
      end
      if (q_ext[41:SQ_W-1] != {3{q_ext[41]}}) begin
         q_sat = q_ext[41] ? {1'b1, {(SQ_W-1){1'b0}}} : {1'b0, {(SQ_W-1){1'b1}}};
      end else begin
         q_sat = q_ext[SQ_W-1:0];
      end
   end

   // Spread and one restoring division step.
   logic signed [50:0] d_val;
   logic [DW:0]        div_t;
   logic               div_ge;
   logic [DW-1:0]      rem_in;
   logic [QW-1:0]      quo_in;

   assign d_val  = 51'(nq_ff) - 51'(ss_ff);
   assign div_t  = {rem_ff, (step_ff == 6'd62)};
   assign div_ge = div_t >= {1'b0, dvs_ff};
   assign rem_in = div_ge ? DW'(div_t - {1'b0, dvs_ff}) : div_t[DW-1:0];
   assign quo_in = {quo_ff[QW-2:0], div_ge};

   // One digit of the integer square root.
   logic [QW-1:0] sq_trial;
   logic          sq_ge;

   assign sq_trial = r_ff + b_ff;
   assign sq_ge    = x_ff >= sq_trial;

   // Control.
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      step_in  = step_ff;
      win_in   = csr_we ? csr_wdata : win_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_ENTRY) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_MOD;
               step_in  = 6'd1;
            end
         end
         ST_MOD: begin
            step_in = step_ff - 6'd1;
            if (step_ff == 6'd0) begin
               state_in = ST_READ;
            end
         end
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_MULT;
         ST_MULT:   state_in = ST_DIFF;
         ST_DIFF: begin
            state_in = (d_val > 51'sd0) ? ST_DIV : ST_DONE;
            step_in  = 6'd62;
         end
         ST_DIV: begin
            step_in = step_ff - 6'd1;
            if (step_ff == 6'd0) begin
               state_in = ST_SQRT;
               step_in  = 6'd31;
            end
         end
         ST_SQRT: begin
            step_in = step_ff - 6'd1;
            if (step_ff == 6'd0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         step_ff  <= '0;
         win_ff   <= WIN_RESET;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         step_ff  <= step_in;
         win_ff   <= win_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            idx_ff <= req_ch.series_index;
            nw_ff  <= req_ch.new_sample;
            od_ff  <= req_ch.old_sample;
            rst_ff <= req_ch.restart;
            mod_ff <= '0;
         end
         ST_MOD: begin
            if (step_ff != 6'd0) begin
               qest_ff <= quo_est;
            end else begin
               mod_ff <= mod_in;
            end
            nsq_ff <= nw_ff * nw_ff;
            osq_ff <= od_ff * od_ff;
         end
         ST_UPDATE: begin
            s_ff <= s_sat;
            q_ff <= q_sat;
         end
         ST_MULT: begin
            nq_ff <= $signed({1'b0, win_ff}) * q_ff;
            ss_ff <= s_ff * s_ff;
         end
         ST_DIFF: begin
            dvs_ff  <= d_val[DW-1:0];
            rem_ff  <= '0;
            quo_ff  <= '0;
            inv_ff  <= '0;
            zero_ff <= !(d_val > 51'sd0);
         end
         ST_DIV: begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            if (step_ff == 6'd0) begin
               x_ff <= quo_in;
               r_ff <= '0;
               b_ff <= {1'b1, {(QW-1){1'b0}}};
            end
         end
         ST_SQRT: begin
            if (sq_ge) begin
               x_ff <= x_ff - sq_trial;
               r_ff <= (r_ff >> 1) + b_ff;
               if (step_ff == 6'd0) begin
                  inv_ff <= INV_W'((r_ff >> 1) + b_ff);
               end
            end else begin
               r_ff <= r_ff >> 1;
               if (step_ff == 6'd0) begin
                  inv_ff <= INV_W'(r_ff >> 1);
               end
            end
            b_ff <= b_ff >> 2;
         end
         default: begin
         end
      endcase
   end

   // State memory: {sum of squares, sum} per series.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         mem[clr_ff] <= '0;
      end else if (state_ff == ST_UPDATE) begin
         mem[addr] <= {q_sat, s_sat};
      end
      if (state_ff == ST_READ) begin
         rdata_ff <= mem[addr];
      end
   end

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = (state_ff == ST_DONE);
   assign rsp_ch.series_out     = idx_ff;
   assign rsp_ch.window_sum     = s_ff;
   assign rsp_ch.inverse_spread = inv_ff;
   assign rsp_ch.zero_spread    = zero_ff;

endmodule

FILE: rtl/core/swis_checker.sv
// ----------------------------------------------------------------------------
// swis_checker
// Port-level assertions for the sliding-window inverse spread block.
// ----------------------------------------------------------------------------
module swis_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [swis_pkg::INV_W-1:0] inverse_spread,
   input logic                       zero_spread
);
   import swis_pkg::*;

   // A result waiting to be taken holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(inverse_spread))
      else $error("result changed while stalled");

   // Only one transaction is in flight at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is pending");

   // The memory clearing pass follows every reset.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("transaction possible right after reset");

   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && zero_spread |-> inverse_spread == '0)
      else $error("nonzero inverse spread with zero spread flag");

   a_inv_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inverse_spread <= INV_W'(64'h8000_0000))
      else $error("inverse spread above one");

endmodule

bind sliding_window_inverse_spread swis_checker u_swis_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .inverse_spread (rsp_ch.inverse_spread),
   .zero_spread    (rsp_ch.zero_spread)
);
